// ----- design/lnb_pkg.sv -----
// ----------------------------------------------------------------------------
// lnb_pkg
// Shared constants and types of the long-name directory entry builder.
// ----------------------------------------------------------------------------
`default_nettype none

package lnb_pkg;

   localparam int MAX_NAME_CHARS_DEF = 255;
   localparam int CHUNK_CHARS        = 13;
   localparam int SHORT_LEN          = 11;
   localparam int TILDE_POS          = 6;
   localparam int ONE_POS            = 7;
   localparam int JOB_DEPTH          = 2;

   localparam int LEN_W     = 8;     // name length and store index
   localparam int GIDX_W    = 9;     // character index across a whole name (up to 260)
   localparam int CHUNK_W   = 5;     // chunk count, up to 20
   localparam int COL_W     = 4;     // character within a chunk
   localparam int SIDX_W    = 4;     // short-name byte index
   localparam int CHAR_W    = 16;
   localparam int ENTRY_W   = CHUNK_CHARS * CHAR_W;

   localparam logic       CMD_SHORT = 1'b0;
   localparam logic       CMD_LONG  = 1'b1;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [CHAR_W-1:0] CHAR_TERM = 16'h0000;
   localparam logic [CHAR_W-1:0] CHAR_FILL = 16'hFFFF;

   // one finished name waiting for the entry sequencer
   typedef struct packed {
      logic               bank;
      logic [LEN_W-1:0]   len;
      logic [CHUNK_W-1:0] nchunk;
      logic [7:0]         csum;
   } lnb_job_type;

   // name store write from the front end
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [LEN_W-1:0] addr;
      logic [7:0]       data;
   } lnb_wr_type;

   // back end has released a store bank
   typedef struct packed {
      logic valid;
      logic bank;
   } lnb_done_type;

endpackage

`default_nettype wire

// ----- design/lnb_req_if.sv -----
// ----------------------------------------------------------------------------
// lnb_req_if
// Input channel: short-name bytes and long-name characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface lnb_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;
   logic       last_char;

   modport source (output valid, command, data_byte, last_char, input ready);
   modport sink   (input valid, command, data_byte, last_char, output ready);
endinterface

`default_nettype wire

// ----- design/lnb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lnb_rsp_if
// Result channel: one long-name directory entry per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lnb_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  slot_position;
   logic [6:0]  order_byte;
   logic [7:0]  short_checksum;
   logic [63:0] chars_first_four;
   logic [63:0] chars_next_four;
   logic [63:0] chars_third_four;
   logic [15:0] char_final;
   logic        run_end;

   modport source (output valid, slot_position, order_byte, short_checksum,
                   chars_first_four, chars_next_four, chars_third_four,
                   char_final, run_end, input ready);
   modport sink   (input valid, slot_position, order_byte, short_checksum,
                   chars_first_four, chars_next_four, chars_third_four,
                   char_final, run_end, output ready);
endinterface

`default_nettype wire

// ----- design/lnb_front.sv -----
// ----------------------------------------------------------------------------
// lnb_front
// Takes input items: short-name checksum, name byte storage, job hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lnb_front #(
   parameter int MAX_NAME_CHARS = lnb_pkg::MAX_NAME_CHARS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lnb_req_if.sink                   req,
   output lnb_pkg::lnb_wr_type       wr,
   output logic                      push,
   output lnb_pkg::lnb_job_type      push_job,
   input  wire logic                 fifo_full,
   input  wire lnb_pkg::lnb_done_type done
);

   logic [lnb_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [lnb_pkg::COL_W-1:0]   col_ff, col_in;
   logic [lnb_pkg::CHUNK_W-1:0] nchunk_ff, nchunk_in;
   logic [lnb_pkg::SIDX_W-1:0]  sidx_ff, sidx_in;
   logic [7:0]                  csum_ff, csum_in;
   logic                        bank_ff, bank_in;
   logic [1:0]                  busy_ff, busy_in;
   logic                        accept;
   logic [7:0]                  sbyte;

   // the bank being filled must not still be under emission
   assign req.ready = !busy_ff[bank_ff] && !fifo_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      len_in    = len_ff;
      col_in    = col_ff;
      nchunk_in = nchunk_ff;
      sidx_in   = sidx_ff;
      csum_in   = csum_ff;
      bank_in   = bank_ff;
      busy_in   = busy_ff;
      wr        = '0;
      push      = 1'b0;
      push_job  = '0;
      sbyte     = req.data_byte;

      if (sidx_ff == lnb_pkg::SIDX_W'(lnb_pkg::TILDE_POS)) begin
         sbyte = lnb_pkg::CHAR_TILDE;
      end else if (sidx_ff == lnb_pkg::SIDX_W'(lnb_pkg::ONE_POS)) begin
         sbyte = lnb_pkg::CHAR_ONE;
      end

      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end

      if (accept && req.command == lnb_pkg::CMD_SHORT) begin
         if (sidx_ff < lnb_pkg::SIDX_W'(lnb_pkg::SHORT_LEN)) begin
            csum_in = {csum_ff[0], csum_ff[7:1]} + sbyte;
            sidx_in = sidx_ff + 1'b1;
         end
      end

      if (accept && req.command == lnb_pkg::CMD_LONG) begin
         if (len_ff < lnb_pkg::LEN_W'(MAX_NAME_CHARS)) begin
            wr.en   = 1'b1;
            wr.bank = bank_ff;
            wr.addr = len_ff;
            wr.data = req.data_byte;
            len_in  = len_ff + 1'b1;
            if (col_ff == '0) begin
               nchunk_in = nchunk_ff + 1'b1;
            end
            if (col_ff == lnb_pkg::COL_W'(lnb_pkg::CHUNK_CHARS - 1)) begin
               col_in = '0;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         if (req.last_char) begin
            push            = 1'b1;
            push_job.bank   = bank_ff;
            push_job.len    = len_in;
            push_job.nchunk = nchunk_in;
            push_job.csum   = csum_ff;
            busy_in[bank_ff] = 1'b1;
            bank_in   = !bank_ff;
            len_in    = '0;
            col_in    = '0;
            nchunk_in = '0;
            sidx_in   = '0;
            csum_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         col_ff    <= '0;
         nchunk_ff <= '0;
         sidx_ff   <= '0;
         csum_ff   <= '0;
         bank_ff   <= 1'b0;
         busy_ff   <= '0;
      end else begin
         len_ff    <= len_in;
         col_ff    <= col_in;
         nchunk_ff <= nchunk_in;
         sidx_ff   <= sidx_in;
         csum_ff   <= csum_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/lnb_job_fifo.sv -----
// ----------------------------------------------------------------------------
// lnb_job_fifo
// Short queue of finished names between front end and entry sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lnb_job_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lnb_pkg::lnb_job_type push_job,
   input  wire logic                 pop,
   output lnb_pkg::lnb_job_type      head,
   output logic                      full,
   output logic                      empty
);

   localparam int PW = (lnb_pkg::JOB_DEPTH > 1) ? $clog2(lnb_pkg::JOB_DEPTH) : 1;
   localparam int CW = $clog2(lnb_pkg::JOB_DEPTH + 1);

   lnb_pkg::lnb_job_type entry_ff [lnb_pkg::JOB_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = count_ff == CW'(lnb_pkg::JOB_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(lnb_pkg::JOB_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(lnb_pkg::JOB_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- design/lnb_back.sv -----
// ----------------------------------------------------------------------------
// lnb_back
// Two-bank name store and entry sequencer: reads 13 characters per entry,
// one per cycle, and hands each entry to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lnb_back #(
   parameter int MAX_NAME_CHARS = lnb_pkg::MAX_NAME_CHARS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lnb_pkg::lnb_wr_type  wr,
   input  wire lnb_pkg::lnb_job_type head,
   input  wire logic                 fifo_empty,
   output logic                      pop,
   output lnb_pkg::lnb_done_type     done,
   lnb_rsp_if.source                 rsp
);

   localparam int AW        = $clog2(MAX_NAME_CHARS);
   localparam int MEM_DEPTH = 2 ** (AW + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FILL  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_TERM = 2'd1;
   localparam logic [1:0] KIND_FILL = 2'd2;

   logic [7:0] mem [MEM_DEPTH];

   logic [1:0]                   state_ff, state_in;
   lnb_pkg::lnb_job_type         job_ff, job_in;
   logic [lnb_pkg::GIDX_W-1:0]   g_ff, g_in;
   logic [lnb_pkg::COL_W-1:0]    k_ff, k_in;
   logic [lnb_pkg::CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [1:0]                   pend_kind_ff, pend_kind_in;
   logic [7:0]                   rd_data_ff;
   logic [lnb_pkg::ENTRY_W-1:0]  chars_ff;
   logic [lnb_pkg::CHAR_W-1:0]   char_code;
   logic [lnb_pkg::GIDX_W-1:0]   len_wide;
   logic                         final_chunk;
   logic                         load_ok;
   logic                         load;

   logic                         rsp_valid_ff;
   logic [4:0]                   slot_ff;
   logic [6:0]                   order_ff;
   logic [7:0]                   csum_ff;
   logic [lnb_pkg::ENTRY_W-1:0]  entry_ff;
   logic                         run_end_ff;

   // name store: one write port from the front end, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[{wr.bank, wr.addr[AW-1:0]}] <= wr.data;
      end
      rd_data_ff <= mem[{job_ff.bank, g_ff[AW-1:0]}];
   end

   assign len_wide    = lnb_pkg::GIDX_W'(job_ff.len);
   assign final_chunk = chunk_ff == job_ff.nchunk - 1'b1;
   assign load_ok     = !rsp_valid_ff || rsp.ready;
   assign load        = state_ff == S_OUT && load_ok;

   always_comb begin
      case (pend_kind_ff)
         KIND_BYTE: char_code = {8'h00, rd_data_ff};
         KIND_TERM: char_code = lnb_pkg::CHAR_TERM;
         default:   char_code = lnb_pkg::CHAR_FILL;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      g_in          = g_ff;
      k_in          = k_ff;
      chunk_in      = chunk_ff;
      pend_valid_in = 1'b0;
      pend_kind_in  = pend_kind_ff;
      pop           = 1'b0;
      done          = '0;

      case (state_ff)
         S_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               job_in   = head;
               g_in     = '0;
               k_in     = '0;
               chunk_in = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            // read issued this cycle, classified for capture next cycle
            pend_valid_in = 1'b1;
            if (g_ff < len_wide) begin
               pend_kind_in = KIND_BYTE;
            end else if (g_ff == len_wide) begin
               pend_kind_in = KIND_TERM;
            end else begin
               pend_kind_in = KIND_FILL;
            end
            g_in = g_ff + 1'b1;
            if (k_ff == lnb_pkg::COL_W'(lnb_pkg::CHUNK_CHARS - 1)) begin
               k_in     = '0;
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (load_ok) begin
               if (final_chunk) begin
                  done.valid = 1'b1;
                  done.bank  = job_ff.bank;
                  state_in   = S_IDLE;
               end else begin
                  chunk_in = chunk_ff + 1'b1;
                  state_in = S_FILL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      g_ff         <= g_in;
      k_ff         <= k_in;
      chunk_ff     <= chunk_in;
      pend_kind_ff <= pend_kind_in;
      // character 0 ends up in the lowest 16 bits after 13 shifts
      if (pend_valid_ff) begin
         chars_ff <= {char_code, chars_ff[lnb_pkg::ENTRY_W-1:lnb_pkg::CHAR_W]};
      end
      if (load) begin
         slot_ff    <= job_ff.nchunk - 1'b1 - chunk_ff;
         order_ff   <= {final_chunk, 1'b0, chunk_ff + 1'b1};
         csum_ff    <= job_ff.csum;
         entry_ff   <= chars_ff;
         run_end_ff <= final_chunk;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.slot_position    = slot_ff;
   assign rsp.order_byte       = order_ff;
   assign rsp.short_checksum   = csum_ff;
   assign rsp.chars_first_four = entry_ff[63:0];
   assign rsp.chars_next_four  = entry_ff[127:64];
   assign rsp.chars_third_four = entry_ff[191:128];
   assign rsp.char_final       = entry_ff[207:192];
   assign rsp.run_end          = run_end_ff;

endmodule

`default_nettype wire

// ----- design/long_name_dir_entry_builder_core.sv -----
// ----------------------------------------------------------------------------
// long_name_dir_entry_builder_core
// Builds long-file-name directory entries from a short name and name bytes.
// ----------------------------------------------------------------------------
//  channel   dir  handshake    payload
//  req_ch    in   valid/ready  command, data_byte, last_char
//  rsp_ch    out  valid/ready  slot, order, checksum, 13 chars, run_end
//
//  Input items are taken one per cycle; a new name waits only while its store
//  bank is still being emitted (two banks, two-entry job queue).
//  Each entry runs through the name store reads, the capture of its last character
//  and the load of the output register; an idle state first takes a name's job.
//  The single read port of the name store sets this pace.
//  Reset is synchronous and clears control state; the name store is not cleared.
//  Either side may stall; the output register holds an entry until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module long_name_dir_entry_builder_core #(
   parameter int MAX_NAME_CHARS = lnb_pkg::MAX_NAME_CHARS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   lnb_req_if.sink   req_ch,
   lnb_rsp_if.source rsp_ch
);

   lnb_pkg::lnb_wr_type   wr;
   lnb_pkg::lnb_job_type  push_job;
   lnb_pkg::lnb_job_type  head;
   lnb_pkg::lnb_done_type done;
   logic                  push;
   logic                  pop;
   logic                  fifo_full;
   logic                  fifo_empty;

   lnb_front #(
      .MAX_NAME_CHARS(MAX_NAME_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .wr        (wr),
      .push      (push),
      .push_job  (push_job),
      .fifo_full (fifo_full),
      .done      (done)
   );

   lnb_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   lnb_back #(
      .MAX_NAME_CHARS(MAX_NAME_CHARS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .head       (head),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .done       (done),
      .rsp        (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- design/lnb_checker.sv -----
// ----------------------------------------------------------------------------
// lnb_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lnb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [4:0]  slot_position,
   input wire logic [6:0]  order_byte,
   input wire logic [63:0] chars_first_four,
   input wire logic        run_end
);

   // a waiting entry holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(order_byte)
         && $stable(slot_position) && $stable(chars_first_four))
      else $error("result entry changed while stalled");

   // last entry of a run carries the final-chunk flag and sits at slot zero
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_end |-> order_byte[6] && slot_position == 5'd0)
      else $error("run end without final flag or at nonzero slot");

   a_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !run_end |-> !order_byte[6] && slot_position != 5'd0)
      else $error("final flag or slot zero before run end");

   a_order_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> order_byte[4:0] != 5'd0 && !order_byte[5])
      else $error("bad order number");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind long_name_dir_entry_builder_core lnb_checker u_lnb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .slot_position    (rsp_ch.slot_position),
   .order_byte       (rsp_ch.order_byte),
   .chars_first_four (rsp_ch.chars_first_four),
   .run_end          (rsp_ch.run_end)
);

`default_nettype wire
